### design/gbba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped bitmap block allocator package
// Shared types, codes and field widths for the allocator and its helpers.
// ----------------------------------------------------------------------------
package gbba_pkg;

  // Bitmap storage is organized as 32-bit words.
  localparam int WORD_W     = 32;
  localparam int WORD_IDX_W = 5;

  // Widths of the response block fields and of the per-group used count.
  localparam int BLK_W = 14;
  localparam int CNT_W = 11;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [BLK_W-1:0] TOT_MAX = '1;

  // Request function codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_DONE          = 2'd0;
  localparam logic [1:0] ST_OUT_OF_BLOCKS = 2'd1;
  localparam logic [1:0] ST_IGNORED       = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_GROUP_COUNT      = 2'd0;
  localparam logic [1:0] REG_GROUP_SIZE       = 2'd1;
  localparam logic [1:0] REG_FIRST_DATA_BLOCK = 2'd2;

  typedef struct packed {
    logic        func;
    logic [31:0] block_number;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] allocated_block;
    logic [1:0]       status;
    logic [BLK_W-1:0] blocks_in_use;
  } rsp_t;

  // Result of the first-clear-bit search over one bitmap word.
  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] idx;
  } find_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_A_GROUP,
    S_A_CNT,
    S_A_SCAN,
    S_F_DIV,
    S_F_READ,
    S_DONE
  } state_t;

endpackage

### design/grouped_bitmap_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped bitmap block allocator
// Allocates and frees blocks in a usage bitmap split into block groups, and
// keeps a used count per group and a total used count.
// ----------------------------------------------------------------------------
// Processing: an allocate visits the groups in order, skips a group whose count says
// full and reads its bitmap words until a clear bit is found; a free of block zero
// is answered directly, any other free finds its group by repeated subtraction.
// Requests are handled one at a time; the next is taken once the response is loaded.
// Reset starts a clearing pass over every bitmap word (256 by default) and group count
// during which no request is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator import gbba_pkg::*; #(
  parameter int MAX_GROUPS       = 8,
  parameter int MAX_GROUP_BLOCKS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_data,
  // Response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp_data,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WPG  = (MAX_GROUP_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WB   = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int GB   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int NGW  = $clog2(MAX_GROUPS + 1);
  localparam int SZW  = $clog2(MAX_GROUP_BLOCKS + 1);
  localparam int AW   = GB + WB;
  localparam int OFFW = WB + WORD_IDX_W;

  // Configuration registers.
  logic [3:0]  group_count;
  logic [10:0] group_size;
  logic        first_data_block;

  // Sequencer and datapath registers.
  state_t           state, state_next;
  logic [AW-1:0]    clr_addr, clr_addr_next;
  logic [NGW-1:0]   grp, grp_next;
  logic [WB-1:0]    w, w_next;
  logic [BLK_W-1:0] base, base_next;
  logic [31:0]      rem, rem_next;
  logic [BLK_W-1:0] res_blk, res_blk_next;
  logic [1:0]       res_st, res_st_next;
  logic [BLK_W-1:0] total_used, total_used_next;

  // Memories and their ports.
  logic [WORD_W-1:0] bm_mem [0:(1 << AW) - 1];
  logic [CNT_W-1:0]  cnt_mem [0:(1 << GB) - 1];
  logic              bm_we, cnt_we;
  logic [AW-1:0]     bm_waddr, bm_raddr;
  logic [WORD_W-1:0] bm_wdata, bm_rdata;
  logic [GB-1:0]     cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

  // Derived values.
  logic [NGW-1:0]    ng;
  logic [SZW-1:0]    sz;
  logic [GB-1:0]     grp_idx;
  logic              grp_over, rem_fits, cnt_full, last_word, bit_set;
  logic [WORD_W-1:0] vmask, masked;
  find_t             find;
  logic [WORD_IDX_W-1:0] bit_sel;
  logic [WB-1:0]     word_sel;
  logic [CNT_W-1:0]  cnt_inc, cnt_dec;
  logic              req_accept, rsp_free, cfg_write;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count      <= 4'd8;
      group_size       <= 11'd1024;
      first_data_block <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_GROUP_COUNT:      group_count      <= pwdata[3:0];
        REG_GROUP_SIZE:       group_size       <= pwdata[10:0];
        REG_FIRST_DATA_BLOCK: first_data_block <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GROUP_COUNT:      prdata = {28'd0, group_count};
      REG_GROUP_SIZE:       prdata = {21'd0, group_size};
      REG_FIRST_DATA_BLOCK: prdata = {31'd0, first_data_block};
      default:              prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Effective group count and size
  // ------------------------------------------------------------------
  always_comb begin
    if (32'(group_count) > MAX_GROUPS) begin
      ng = NGW'(MAX_GROUPS);
    end else begin
      ng = NGW'(group_count);
    end
    if (group_size == 11'd0) begin
      sz = SZW'(1);
    end else if (32'(group_size) > MAX_GROUP_BLOCKS) begin
      sz = SZW'(MAX_GROUP_BLOCKS);
    end else begin
      sz = SZW'(group_size);
    end
  end

  // ------------------------------------------------------------------
  // Shared compares and the word search
  // ------------------------------------------------------------------
  assign grp_idx   = grp[GB-1:0];
  assign grp_over  = 32'(grp) >= 32'(ng);
  assign rem_fits  = rem < 32'(sz);
  assign cnt_full  = 32'(cnt_rdata) >= 32'(sz);
  assign last_word = ((32'(w) + 32'd1) << WORD_IDX_W) >= 32'(sz);
  assign bit_sel   = rem[WORD_IDX_W-1:0];
  assign word_sel  = rem[OFFW-1:WORD_IDX_W];
  assign bit_set   = bm_rdata[bit_sel];
  assign cnt_inc   = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 11'd1;
  assign cnt_dec   = (cnt_rdata == '0) ? cnt_rdata : cnt_rdata - 11'd1;

  // Bits at or beyond the group size count as used during the scan.
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      vmask[i] = 32'({w, WORD_IDX_W'(i)}) < 32'(sz);
    end
  end
  assign masked = bm_rdata | ~vmask;

  gbba_first_zero u_first_zero (
    .word (masked),
    .find (find)
  );

  // ------------------------------------------------------------------
  // Handshakes
  // ------------------------------------------------------------------
  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;

  // ------------------------------------------------------------------
  // Next state
  // ------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (&clr_addr) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_accept) begin
          if (req_data.func == FUNC_ALLOC) begin
            state_next = S_A_GROUP;
          end else if (req_data.block_number == 32'd0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_F_DIV;
          end
        end
      end
      S_A_GROUP: begin
        state_next = grp_over ? S_DONE : S_A_CNT;
      end
      S_A_CNT: begin
        state_next = cnt_full ? S_A_GROUP : S_A_SCAN;
      end
      S_A_SCAN: begin
        if (find.found) begin
          state_next = S_DONE;
        end else if (last_word) begin
          state_next = S_A_GROUP;
        end
      end
      S_F_DIV: begin
        if (grp_over) begin
          state_next = S_DONE;
        end else if (rem_fits) begin
          state_next = S_F_READ;
        end
      end
      S_F_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // ------------------------------------------------------------------
  // Datapath and memory controls
  // ------------------------------------------------------------------
  always_comb begin
    clr_addr_next   = clr_addr;
    grp_next        = grp;
    w_next          = w;
    base_next       = base;
    rem_next        = rem;
    res_blk_next    = res_blk;
    res_st_next     = res_st;
    total_used_next = total_used;
    bm_we           = 1'b0;
    bm_waddr        = {grp_idx, w};
    bm_wdata        = bm_rdata;
    bm_raddr        = {grp_idx, word_sel};
    cnt_we          = 1'b0;
    cnt_waddr       = grp_idx;
    cnt_wdata       = cnt_rdata;
    case (state)
      S_CLEAR: begin
        bm_we         = 1'b1;
        bm_waddr      = clr_addr;
        bm_wdata      = '0;
        cnt_we        = 1'b1;
        cnt_waddr     = clr_addr[AW-1 -: GB];
        cnt_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
      end
      S_IDLE: begin
        grp_next  = '0;
        base_next = '0;
        rem_next  = req_data.block_number - 32'(first_data_block);
        if (req_data.func == FUNC_FREE) begin
          res_blk_next = '0;
          res_st_next  = ST_IGNORED;
        end
      end
      S_A_GROUP: begin
        res_blk_next = '0;
        res_st_next  = ST_OUT_OF_BLOCKS;
      end
      S_A_CNT: begin
        w_next   = '0;
        bm_raddr = {grp_idx, WB'(0)};
        if (cnt_full) begin
          grp_next  = grp + 1'b1;
          base_next = base + BLK_W'(sz);
        end
      end
      S_A_SCAN: begin
        bm_raddr = {grp_idx, WB'(w + 1'b1)};
        if (find.found) begin
          bm_we           = 1'b1;
          bm_wdata        = bm_rdata | (WORD_W'(1) << find.idx);
          cnt_we          = 1'b1;
          cnt_wdata       = cnt_inc;
          total_used_next = (total_used == TOT_MAX) ? total_used : total_used + 1'b1;
          res_blk_next    = base + BLK_W'({w, find.idx}) + BLK_W'(first_data_block);
          res_st_next     = ST_DONE;
        end else if (last_word) begin
          grp_next  = grp + 1'b1;
          base_next = base + BLK_W'(sz);
        end else begin
          w_next = w + 1'b1;
        end
      end
      S_F_DIV: begin
        // Repeated subtraction of the group size yields group and offset.
        if (!grp_over && !rem_fits) begin
          rem_next = rem - 32'(sz);
          grp_next = grp + 1'b1;
        end
      end
      S_F_READ: begin
        if (bit_set) begin
          bm_we           = 1'b1;
          bm_waddr        = {grp_idx, word_sel};
          bm_wdata        = bm_rdata & ~(WORD_W'(1) << bit_sel);
          cnt_we          = 1'b1;
          cnt_wdata       = cnt_dec;
          total_used_next = (total_used == '0) ? total_used : total_used - 1'b1;
          res_st_next     = ST_DONE;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      total_used <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      total_used <= total_used_next;
    end
  end

  always_ff @(posedge clk) begin
    grp     <= grp_next;
    w       <= w_next;
    base    <= base_next;
    rem     <= rem_next;
    res_blk <= res_blk_next;
    res_st  <= res_st_next;
  end

  // Response register: loads when the finished result finds it free.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp_data.allocated_block <= res_blk;
      rsp_data.status          <= res_st;
      rsp_data.blocks_in_use   <= total_used;
    end
  end

  // ------------------------------------------------------------------
  // Bitmap and count memories
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_rdata <= bm_mem[bm_raddr];
  end

  // The count read follows the current group register every cycle.
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata <= cnt_mem[grp_idx];
  end

`ifndef ASSERT_OFF
  // The word scan only ever runs inside a configured group.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_SCAN) |-> (32'(grp) < 32'(ng)))
    else $error("bitmap scan outside the configured groups");

  // A successful free lowers a nonzero total by exactly one.
  a_free_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_READ && bit_set && total_used != '0)
      |=> (total_used == $past(total_used) - 1'b1))
    else $error("total used count not decremented by a free");

  // An out of blocks answer carries no block number.
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.status == ST_OUT_OF_BLOCKS)
      |-> (rsp_data.allocated_block == '0))
    else $error("out of blocks response with a block number");

  // A finished result moves into a free response register and the sequencer returns to idle.
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_free) |=> (rsp_valid && state == S_IDLE))
    else $error("finished result not loaded into the response register");
`endif

endmodule

### design/gbba_first_zero.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First clear bit finder
// Returns the lowest clear bit position of one bitmap word, if there is one.
// ----------------------------------------------------------------------------
module gbba_first_zero import gbba_pkg::*; (
  input  logic [WORD_W-1:0] word,
  output find_t             find
);

  // Scan from the top down so that the lowest clear bit wins.
  always_comb begin
    find.found = 1'b0;
    find.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        find.found = 1'b1;
        find.idx   = WORD_IDX_W'(i);
      end
    end
  end

endmodule

### tb/grouped_bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grouped bitmap block allocator testbench
// Drives allocate and free requests across several group layouts, and keeps a
// shadow of the usage bitmap, the per-group counts and the total count to
// predict every response. Responses are checked field by field, in order.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator_tb;
  import gbba_pkg::*;

  localparam int N_GROUPS   = 8;
  localparam int GROUP_SPAN = 1024;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_data = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the allocator state and its configuration.
  bit               usage_map [0:N_GROUPS*GROUP_SPAN-1];
  logic [CNT_W-1:0] grp_used [0:N_GROUPS-1];
  logic [BLK_W-1:0] used_total = '0;
  logic [3:0]       cfg_groups = 4'd8;
  logic [10:0]      cfg_size = 11'd1024;
  logic             cfg_fdb = 1'b1;

  req_t pending_ops [$];
  rsp_t expected_rsps [$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          failures = 0;
  int unsigned cycle_count = 0;

  grouped_bitmap_block_allocator #(
    .MAX_GROUPS      (N_GROUPS),
    .MAX_GROUP_BLOCKS(GROUP_SPAN)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Number of groups actually scanned; larger settings saturate.
  function automatic int unsigned active_groups();
    return (cfg_groups > N_GROUPS) ? N_GROUPS : cfg_groups;
  endfunction

  // Blocks per group; zero acts as one and larger values saturate.
  function automatic int unsigned group_blocks();
    if (cfg_size == 0) return 1;
    return (cfg_size > GROUP_SPAN) ? GROUP_SPAN : cfg_size;
  endfunction

  // Applies one request beat to the shadow state and returns its response.
  function automatic rsp_t predict_block_op(req_t beat);
    int unsigned ng, sz, g, o, rel;
    bit          hit;
    rsp_t        res;
    ng  = active_groups();
    sz  = group_blocks();
    hit = 1'b0;
    res = '0;
    if (beat.func == FUNC_ALLOC) begin
      res.status = ST_OUT_OF_BLOCKS;
      // Groups whose count says full are skipped without a look at the bitmap.
      for (g = 0; g < ng && !hit; g++) begin
        if (grp_used[g] < sz) begin
          for (o = 0; o < sz && !hit; o++) begin
            if (!usage_map[g*GROUP_SPAN + o]) begin
              usage_map[g*GROUP_SPAN + o] = 1'b1;
              if (grp_used[g] != CNT_MAX) grp_used[g] = grp_used[g] + 1'b1;
              if (used_total != TOT_MAX) used_total = used_total + 1'b1;
              res.allocated_block = BLK_W'(g*sz + o + cfg_fdb);
              res.status = ST_DONE;
              hit = 1'b1;
            end
          end
        end
      end
    end else begin
      res.status = ST_IGNORED;
      // Block zero, blocks past the last group and blocks already free are ignored.
      if (beat.block_number != 0) begin
        rel = beat.block_number - cfg_fdb;
        g   = rel / sz;
        o   = rel % sz;
        if (g < ng && usage_map[g*GROUP_SPAN + o]) begin
          usage_map[g*GROUP_SPAN + o] = 1'b0;
          if (grp_used[g] != 0) grp_used[g] = grp_used[g] - 1'b1;
          if (used_total != 0) used_total = used_total - 1'b1;
          res.status = ST_DONE;
        end
      end
    end
    res.blocks_in_use = used_total;
    return res;
  endfunction

  // Request driver: a new beat is offered once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_valid <= 1'b1;
        req_data  <= pending_ops.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response stall pattern.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Response checker, then prediction for the request beat taken at this edge.
  always @(posedge clk) begin : rsp_monitor
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          failures++;
          $display("%0t: response with none expected: block %0d status %0d in_use %0d",
                   $time, rsp_data.allocated_block, rsp_data.status,
                   rsp_data.blocks_in_use);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_data.allocated_block !== want.allocated_block) begin
            failures++;
            $display("%0t: allocated_block mismatch: expected %0d actual %0d",
                     $time, want.allocated_block, rsp_data.allocated_block);
          end
          if (rsp_data.status !== want.status) begin
            failures++;
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, rsp_data.status);
          end
          if (rsp_data.blocks_in_use !== want.blocks_in_use) begin
            failures++;
            $display("%0t: blocks_in_use mismatch: expected %0d actual %0d",
                     $time, want.blocks_in_use, rsp_data.blocks_in_use);
          end
        end
      end
      if (req_valid && !req_stall) expected_rsps.push_back(predict_block_op(req_data));
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // One register write: setup cycle, then access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GROUP_COUNT:      cfg_groups = value[3:0];
      REG_GROUP_SIZE:       cfg_size   = value[10:0];
      REG_FIRST_DATA_BLOCK: cfg_fdb    = value[0];
      default: ;
    endcase
  endtask

  task automatic set_layout(input logic [3:0] gc, input logic [10:0] gs, input logic fdb);
    reg_write(REG_GROUP_COUNT, 32'(gc));
    reg_write(REG_GROUP_SIZE, 32'(gs));
    reg_write(REG_FIRST_DATA_BLOCK, 32'(fdb));
  endtask

  task automatic queue_op(input logic f, input logic [31:0] blk);
    req_t beat;
    beat.func         = f;
    beat.block_number = blk;
    pending_ops.push_back(beat);
  endtask

  // Holds off until every queued beat is answered and the block has settled.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_ops.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Random mix; frees mostly target blocks inside the configured layout.
  task automatic queue_random_ops(input int count);
    int unsigned alloc_pct, span;
    logic [31:0] blk;
    alloc_pct = $urandom_range(35, 70);
    span      = active_groups() * group_blocks();
    repeat (count) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        queue_op(FUNC_ALLOC, $urandom());
      end else begin
        case ($urandom_range(0, 19))
          0:       blk = $urandom();
          1:       blk = 32'd0;
          2:       blk = span + cfg_fdb + $urandom_range(0, 3);
          default: blk = (span == 0) ? 32'($urandom_range(0, 63))
                                     : cfg_fdb + $urandom_range(0, span - 1);
        endcase
        queue_op(FUNC_FREE, blk);
      end
    end
  endtask

  task automatic run_segment(input logic [3:0] gc, input logic [10:0] gs, input logic fdb);
    set_layout(gc, gs, fdb);
    queue_random_ops(135);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < N_GROUPS; i++) grp_used[i] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Full layout: first allocations, a free of block zero, double free,
    // highest valid block, blocks past the last group.
    set_layout(4'd8, 11'd1024, 1'b1);
    send_idle_pct  = 6;
    recv_stall_pct = 60;
    repeat (3) queue_op(FUNC_ALLOC, 32'd0);
    queue_op(FUNC_FREE, 32'd0);
    queue_op(FUNC_FREE, 32'd2);
    queue_op(FUNC_FREE, 32'd2);
    queue_op(FUNC_ALLOC, 32'hFFFF_FFFF);
    queue_op(FUNC_FREE, 32'd8192);
    queue_op(FUNC_FREE, 32'd8193);
    queue_op(FUNC_FREE, 32'hFFFF_FFFF);
    wait_drained();

    // Tiny layout: both groups fill up, then a freed block is taken again past a full group.
    set_layout(4'd2, 11'd3, 1'b0);
    repeat (6) queue_op(FUNC_ALLOC, 32'd0);
    queue_op(FUNC_FREE, 32'd0);
    queue_op(FUNC_FREE, 32'd4);
    queue_op(FUNC_ALLOC, 32'd0);
    wait_drained();

    // No groups in use.
    set_layout(4'd0, 11'd3, 1'b0);
    queue_op(FUNC_ALLOC, 32'd0);
    queue_op(FUNC_FREE, 32'd1);
    wait_drained();

    // Group count above range, group size out of range in both directions.
    set_layout(4'd15, 11'd0, 1'b1);
    queue_op(FUNC_ALLOC, 32'd0);
    queue_op(FUNC_FREE, 32'd3);
    wait_drained();
    set_layout(4'd9, 11'd2047, 1'b1);
    queue_op(FUNC_ALLOC, 32'd0);
    queue_op(FUNC_FREE, 32'd8192);
    wait_drained();

    // Random traffic, sender mostly busy and receiver often stalled.
    run_segment(4'd2, 11'd4, 1'b1);
    run_segment(4'd3, 11'd5, 1'b0);
    run_segment(4'd1, 11'd1, 1'b1);
    run_segment(4'd8, 11'd16, 1'b0);

    // Sender often idle, receiver mostly ready.
    send_idle_pct  = 60;
    recv_stall_pct = 6;
    run_segment(4'd4, 11'd33, 1'b1);
    run_segment(4'd0, 11'd9, 1'b0);
    run_segment(4'd12, 11'd2, 1'b1);
    run_segment(4'd5, 11'd0, 1'b0);

    // Back to back, no idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_segment(4'd2, 11'd2047, 1'b1);
    run_segment(4'd8, 11'd1024, 1'b0);
    run_segment(4'd6, 11'd7, 1'b1);
    run_segment(4'd1, 11'd64, 1'b0);

    repeat (16) @(negedge clk);
    if (expected_rsps.size() != 0) failures++;
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
